// ===== rtl/gif_lzw_pixel_decoder_assert.svh =====
// assertion macros for the lzw pixel decoder
`ifndef GIF_LZW_PIXEL_DECODER_ASSERT_SVH
`define GIF_LZW_PIXEL_DECODER_ASSERT_SVH

`ifndef NO_ASSERTIONS
`define GLZW_ASSERT(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("glzw assertion failed");
`define GLZW_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("glzw implication failed");
`else
`define GLZW_ASSERT(lbl, cond)
`define GLZW_ASSERT_IMP(lbl, ante, cons)
`endif

`endif

// ===== rtl/glzw_pkg.sv =====
package glzw_pkg;

  localparam int MAX_CODE_BITS_DEF  = 12;
  localparam int RESERVOIR_BITS_DEF = 32;
  localparam logic [3:0] ROOT_RESET = 4'd8;
  localparam logic [3:0] ROOT_MIN   = 4'd2;
  localparam logic [3:0] ROOT_MAX   = 4'd8;

  localparam logic [1:0] OP_START = 2'd0;
  localparam logic [1:0] OP_PUSH  = 2'd1;
  localparam logic [1:0] OP_PULL  = 2'd2;

  localparam logic [2:0] ST_PIXEL     = 3'd0;
  localparam logic [2:0] ST_ACCEPTED  = 3'd1;
  localparam logic [2:0] ST_NEED_DATA = 3'd2;
  localparam logic [2:0] ST_END       = 3'd3;
  localparam logic [2:0] ST_FULL      = 3'd4;
  localparam logic [2:0] ST_CIRCULAR  = 3'd5;

  typedef enum logic [2:0] {
    FSM_IDLE,
    FSM_POP,
    FSM_DECODE,
    FSM_WALK,
    FSM_WALK_RD
  } fsm_t;

endpackage

// ===== rtl/gif_lzw_pixel_decoder.sv =====
// channel  direction  handshake          payload
// in_      input      in_valid/in_stall   opcode, data_byte
// out_     output     out_valid/out_stall status, pixel_index
// cfg_     input      cfg_valid/cfg_ready root_code_size
// one item at a time; start, push and unknown ops give their result in the next cycle
// a pull that pops the expansion stack reads the stack memory, then answers from FSM_POP
// a pull that decodes goes to FSM_DECODE, which takes codes until one gives a
// result; a code after the first walks its chain in FSM_WALK and FSM_WALK_RD
// synchronous active-low reset, no clearing pass: roots are computed, not stored
// the input is stalled while an item is in work or a result waits to transfer
`include "gif_lzw_pixel_decoder_assert.svh"

module gif_lzw_pixel_decoder #(
  parameter int MAX_CODE_BITS  = glzw_pkg::MAX_CODE_BITS_DEF,
  parameter int RESERVOIR_BITS = glzw_pkg::RESERVOIR_BITS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [1:0] in_opcode,
  input  logic [7:0] in_data_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [2:0] out_status,
  output logic [7:0] out_pixel_index,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [3:0] cfg_root_code_size
);

  localparam int CW = MAX_CODE_BITS;
  localparam int TS = 1 << CW;
  localparam int HW = $clog2(RESERVOIR_BITS + 1);
  localparam int DW = CW + 8;
  localparam logic [CW:0] TS_V = (CW+1)'(TS);

  logic [DW-1:0] dict_mem [TS];
  logic [7:0]    stack_mem [TS];

  logic [3:0]    root_cfg_r;
  logic [3:0]    active_root_r, active_root_nxt;
  logic [3:0]    width_r, width_nxt;
  logic [CW:0]   nfc_r, nfc_nxt;
  logic [CW:0]   limit_r, limit_nxt;
  logic [CW-1:0] prev_r, prev_nxt;
  logic [7:0]    first_r, first_nxt;
  logic          awaiting_r, awaiting_nxt;
  logic          ended_r, ended_nxt;
  logic [CW:0]   sp_r, sp_nxt;
  logic [RESERVOIR_BITS-1:0] res_r, res_nxt;
  logic [HW-1:0] held_r, held_nxt;
  logic [CW-1:0] cur_r, cur_nxt;
  logic [CW-1:0] incode_r, incode_nxt;
  glzw_pkg::fsm_t state_r, state_nxt;
  logic          out_valid_r, out_valid_nxt;
  logic [2:0]    out_status_r, out_status_nxt;
  logic [7:0]    out_pixel_r, out_pixel_nxt;

  logic [DW-1:0] dict_q_r;
  logic [7:0]    stack_q_r;

  logic          dict_we, dict_re, stack_we, stack_re;
  logic [CW-1:0] dict_waddr, dict_raddr, stack_waddr, stack_raddr;
  logic [DW-1:0] dict_wdata;
  logic [7:0]    stack_wdata;

  logic          in_xfer, slot_free;
  logic [CW:0]   clr, clr_nfc, nfc_inc;
  logic [CW-1:0] code, cmask;
  logic [CW-1:0] rd_prefix;
  logic [7:0]    rd_suffix;
  logic [3:0]    root_clamp;
  logic [HW:0]   held_push;

  assign slot_free = !out_valid_r || !out_stall;
  assign in_stall  = !((state_r == glzw_pkg::FSM_IDLE) && slot_free);
  assign in_xfer   = in_valid && !in_stall;
  assign cfg_ready = 1'b1;
  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_pixel_index = out_pixel_r;

  assign clr       = (CW+1)'(1) << active_root_r;
  assign clr_nfc   = clr + (CW+1)'(2);
  assign cmask     = (CW'(1) << width_r) - CW'(1);
  assign code      = res_r[CW-1:0] & cmask;
  assign nfc_inc   = nfc_r + (CW+1)'(1);
  assign rd_prefix = dict_q_r[DW-1:8];
  assign rd_suffix = dict_q_r[7:0];
  assign held_push = {1'b0, held_r} + (HW+1)'(8);
  assign root_clamp = (root_cfg_r < glzw_pkg::ROOT_MIN) ? glzw_pkg::ROOT_MIN :
                      (root_cfg_r > glzw_pkg::ROOT_MAX) ? glzw_pkg::ROOT_MAX : root_cfg_r;

  always_comb begin
    active_root_nxt = active_root_r;
    width_nxt       = width_r;
    nfc_nxt         = nfc_r;
    limit_nxt       = limit_r;
    prev_nxt        = prev_r;
    first_nxt       = first_r;
    awaiting_nxt    = awaiting_r;
    ended_nxt       = ended_r;
    sp_nxt          = sp_r;
    res_nxt         = res_r;
    held_nxt        = held_r;
    cur_nxt         = cur_r;
    incode_nxt      = incode_r;
    state_nxt       = state_r;
    out_valid_nxt   = out_valid_r && out_stall;
    out_status_nxt  = out_status_r;
    out_pixel_nxt   = out_pixel_r;
    dict_we     = 1'b0;
    dict_waddr  = nfc_r[CW-1:0];
    dict_wdata  = {prev_r, first_r};
    dict_re     = 1'b0;
    dict_raddr  = cur_r;
    stack_we    = 1'b0;
    stack_waddr = sp_r[CW-1:0];
    stack_wdata = rd_suffix;
    stack_re    = 1'b0;
    stack_raddr = sp_r[CW-1:0] - CW'(1);

    unique case (state_r)
      glzw_pkg::FSM_IDLE: begin
        if (in_xfer) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = glzw_pkg::ST_ACCEPTED;
          out_pixel_nxt  = 8'd0;
          if (in_opcode == glzw_pkg::OP_START) begin
            active_root_nxt = root_clamp;
            width_nxt       = root_clamp + 4'd1;
            nfc_nxt         = ((CW+1)'(1) << root_clamp) + (CW+1)'(2);
            limit_nxt       = (CW+1)'(2) << root_clamp;
            sp_nxt          = '0;
            awaiting_nxt    = 1'b1;
            res_nxt         = '0;
            held_nxt        = '0;
            prev_nxt        = '0;
            first_nxt       = '0;
            ended_nxt       = 1'b0;
          end else if (in_opcode == glzw_pkg::OP_PUSH) begin
            if (held_push > (HW+1)'(RESERVOIR_BITS)) begin
              out_status_nxt = glzw_pkg::ST_FULL;
            end else begin
              res_nxt  = res_r | (RESERVOIR_BITS'(in_data_byte) << held_r);
              held_nxt = held_push[HW-1:0];
            end
          end else if (in_opcode == glzw_pkg::OP_PULL) begin
            if (ended_r) begin
              out_status_nxt = glzw_pkg::ST_END;
            end else if (!awaiting_r && sp_r != '0) begin
              out_valid_nxt = 1'b0;
              stack_re      = 1'b1;
              sp_nxt        = sp_r - (CW+1)'(1);
              state_nxt     = glzw_pkg::FSM_POP;
            end else begin
              out_valid_nxt = 1'b0;
              state_nxt     = glzw_pkg::FSM_DECODE;
            end
          end
        end
      end
      glzw_pkg::FSM_POP: begin
        out_valid_nxt  = 1'b1;
        out_status_nxt = glzw_pkg::ST_PIXEL;
        out_pixel_nxt  = stack_q_r;
        state_nxt      = glzw_pkg::FSM_IDLE;
      end
      glzw_pkg::FSM_DECODE: begin
        if (HW'(width_r) > held_r) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = glzw_pkg::ST_NEED_DATA;
          out_pixel_nxt  = 8'd0;
          state_nxt      = glzw_pkg::FSM_IDLE;
        end else begin
          res_nxt  = res_r >> width_r;
          held_nxt = held_r - HW'(width_r);
          if ({1'b0, code} == clr) begin
            width_nxt    = active_root_r + 4'd1;
            nfc_nxt      = clr_nfc;
            limit_nxt    = clr << 1;
            sp_nxt       = '0;
            awaiting_nxt = 1'b1;
          end else if ({1'b0, code} == clr + (CW+1)'(1)) begin
            ended_nxt      = 1'b1;
            sp_nxt         = '0;
            out_valid_nxt  = 1'b1;
            out_status_nxt = glzw_pkg::ST_END;
            out_pixel_nxt  = 8'd0;
            state_nxt      = glzw_pkg::FSM_IDLE;
          end else if (awaiting_r) begin
            out_valid_nxt = 1'b1;
            state_nxt     = glzw_pkg::FSM_IDLE;
            if ({1'b0, code} > clr) begin
              ended_nxt      = 1'b1;
              sp_nxt         = '0;
              out_status_nxt = glzw_pkg::ST_CIRCULAR;
              out_pixel_nxt  = 8'd0;
            end else begin
              awaiting_nxt   = 1'b0;
              first_nxt      = code[7:0];
              prev_nxt       = code;
              out_status_nxt = glzw_pkg::ST_PIXEL;
              out_pixel_nxt  = code[7:0];
            end
          end else begin
            incode_nxt = code;
            state_nxt  = glzw_pkg::FSM_WALK;
            if ({1'b0, code} >= nfc_r) begin
              stack_we    = 1'b1;
              stack_wdata = first_r;
              sp_nxt      = sp_r + (CW+1)'(1);
              cur_nxt     = prev_r;
            end else begin
              cur_nxt = code;
            end
          end
        end
      end
      glzw_pkg::FSM_WALK: begin
        if (sp_r >= TS_V) begin
          ended_nxt      = 1'b1;
          sp_nxt         = '0;
          out_valid_nxt  = 1'b1;
          out_status_nxt = glzw_pkg::ST_CIRCULAR;
          out_pixel_nxt  = 8'd0;
          state_nxt      = glzw_pkg::FSM_IDLE;
        end else if ({1'b0, cur_r} >= clr) begin
          dict_re   = 1'b1;
          state_nxt = glzw_pkg::FSM_WALK_RD;
        end else begin
          first_nxt = cur_r[7:0];
          if (nfc_r < TS_V) begin
            dict_we    = 1'b1;
            dict_wdata = {prev_r, cur_r[7:0]};
            nfc_nxt    = nfc_inc;
            if (nfc_inc >= limit_r && limit_r < TS_V) begin
              limit_nxt = limit_r << 1;
              width_nxt = width_r + 4'd1;
            end
          end
          prev_nxt       = incode_r;
          out_valid_nxt  = 1'b1;
          out_status_nxt = glzw_pkg::ST_PIXEL;
          out_pixel_nxt  = cur_r[7:0];
          state_nxt      = glzw_pkg::FSM_IDLE;
        end
      end
      glzw_pkg::FSM_WALK_RD: begin
        stack_we = 1'b1;
        sp_nxt   = sp_r + (CW+1)'(1);
        if (rd_prefix == cur_r) begin
          ended_nxt      = 1'b1;
          sp_nxt         = '0;
          out_valid_nxt  = 1'b1;
          out_status_nxt = glzw_pkg::ST_CIRCULAR;
          out_pixel_nxt  = 8'd0;
          state_nxt      = glzw_pkg::FSM_IDLE;
        end else begin
          cur_nxt   = rd_prefix;
          state_nxt = glzw_pkg::FSM_WALK;
        end
      end
      default: begin
        state_nxt = glzw_pkg::FSM_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (dict_we) begin
      dict_mem[dict_waddr] <= dict_wdata;
    end
    if (dict_re) begin
      dict_q_r <= dict_mem[dict_raddr];
    end
    if (stack_we) begin
      stack_mem[stack_waddr] <= stack_wdata;
    end
    if (stack_re) begin
      stack_q_r <= stack_mem[stack_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      root_cfg_r    <= glzw_pkg::ROOT_RESET;
      active_root_r <= glzw_pkg::ROOT_RESET;
      width_r       <= glzw_pkg::ROOT_RESET + 4'd1;
      nfc_r         <= ((CW+1)'(1) << glzw_pkg::ROOT_RESET) + (CW+1)'(2);
      limit_r       <= (CW+1)'(2) << glzw_pkg::ROOT_RESET;
      prev_r        <= '0;
      first_r       <= '0;
      awaiting_r    <= 1'b1;
      ended_r       <= 1'b0;
      sp_r          <= '0;
      res_r         <= '0;
      held_r        <= '0;
      state_r       <= glzw_pkg::FSM_IDLE;
      out_valid_r   <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        root_cfg_r <= cfg_root_code_size;
      end
      active_root_r <= active_root_nxt;
      width_r       <= width_nxt;
      nfc_r         <= nfc_nxt;
      limit_r       <= limit_nxt;
      prev_r        <= prev_nxt;
      first_r       <= first_nxt;
      awaiting_r    <= awaiting_nxt;
      ended_r       <= ended_nxt;
      sp_r          <= sp_nxt;
      res_r         <= res_nxt;
      held_r        <= held_nxt;
      state_r       <= state_nxt;
      out_valid_r   <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r        <= cur_nxt;
    incode_r     <= incode_nxt;
    out_status_r <= out_status_nxt;
    out_pixel_r  <= out_pixel_nxt;
  end

  // stack never grows past the table
  `GLZW_ASSERT(a_sp_bound, sp_r <= TS_V)
  // no result may wait while an item is in work
  `GLZW_ASSERT_IMP(a_slot_empty, state_r != glzw_pkg::FSM_IDLE, !out_valid_r)
  `GLZW_ASSERT(a_width_bound, width_r <= 4'(CW))
  `GLZW_ASSERT(a_nfc_bound, nfc_r <= TS_V)

endmodule
